// File: sv/spq_pkg.sv
// types, codes and defaults shared by the stable priority task queue
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_DISPATCH = 2'd1;
    localparam logic [1:0] REQ_RETIRE   = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_FULL        = 2'd1;
    localparam logic [1:0] ST_NO_DISPATCH = 2'd2;
    localparam logic [1:0] ST_NO_RETIRE   = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] task_order;
        logic [7:0] task_tag;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted_tag;
        logic [4:0] queued_count;
    } t_out_word;

    typedef struct packed {
        logic [7:0] order;
        logic [7:0] tag;
        logic       busy;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_WALK,
        S_INS_PUT,
        S_DSP,
        S_RET_SCAN,
        S_RET_SHIFT,
        S_DONE
    } t_state;

endpackage

// File: sv/spq_ram.sv
// generic simple dual-port ram with registered read
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/stable_priority_task_queue.sv
// stable priority task queue: sorted entry ram walked by a sequencer
//
//  channel | valid      | stall       | word
//  --------+------------+-------------+------------------------------
//  in      | i_in_valid | o_in_stall  | i_in_word  (spq_pkg::t_in_word)
//  out     | o_out_valid| i_out_stall | o_out_word (spq_pkg::t_out_word)
//
//  one word at a time; insert and retire walk the held entries,
//  one entry moved per cycle through the ram's two ports
//  the next word is taken while a result still waits in the output register
//  reset is synchronous and clears count, state and output valid only
//  a stalled output holds the sequencer in its final state

module stable_priority_task_queue #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  spq_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output spq_pkg::t_out_word  o_out_word
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    spq_pkg::t_state    r_state, n_state;
    spq_pkg::t_in_word  r_req, n_req;
    spq_pkg::t_out_word r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_idx, n_idx;
    logic [1:0]         r_status, n_status;
    logic [7:0]         r_gtag, n_gtag;

    logic               ram_we;
    logic [CW-1:0]      ram_wptr;
    logic [CW-1:0]      rd_ptr;
    spq_pkg::t_entry    ram_wdata;
    spq_pkg::t_entry    rd_data;
    spq_pkg::t_entry    new_entry;
    logic [spq_pkg::ENTRY_W-1:0] rd_raw;

    logic               in_acc;
    logic               out_free;
    logic               scan_last;
    logic               shift_last;
    logic               ins_here;
    logic [CW+4:0]      cnt_ext;

    spq_ram #(
        .WIDTH(spq_pkg::ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wptr[AW-1:0]),
        .i_wdata(ram_wdata),
        .i_raddr(rd_ptr[AW-1:0]),
        .o_rdata(rd_raw)
    );

    assign rd_data     = spq_pkg::t_entry'(rd_raw);
    assign o_in_stall  = (r_state != spq_pkg::S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign scan_last   = (r_idx + CW'(1)) == r_cnt;
    assign shift_last  = (r_idx + CW'(2)) == r_cnt;
    assign ins_here    = rd_data.order <= r_req.task_order;
    assign cnt_ext     = {5'd0, r_cnt};
    assign new_entry   = '{order: r_req.task_order, tag: r_req.task_tag, busy: 1'b0};
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (in_acc) n_state = spq_pkg::S_DECODE;
            end
            spq_pkg::S_DECODE: begin
                case (r_req.req_type)
                    spq_pkg::REQ_INSERT: begin
                        if (r_cnt == CW'(QUEUE_DEPTH)) n_state = spq_pkg::S_DONE;
                        else if (r_cnt == '0) n_state = spq_pkg::S_INS_PUT;
                        else n_state = spq_pkg::S_INS_WALK;
                    end
                    spq_pkg::REQ_DISPATCH: begin
                        n_state = (r_cnt == '0) ? spq_pkg::S_DONE : spq_pkg::S_DSP;
                    end
                    spq_pkg::REQ_RETIRE: begin
                        n_state = (r_cnt == '0) ? spq_pkg::S_DONE : spq_pkg::S_RET_SCAN;
                    end
                    default: n_state = spq_pkg::S_DONE;
                endcase
            end
            spq_pkg::S_INS_WALK: begin
                if (ins_here) n_state = spq_pkg::S_DONE;
                else if (r_idx == CW'(1)) n_state = spq_pkg::S_INS_PUT;
            end
            spq_pkg::S_INS_PUT: n_state = spq_pkg::S_DONE;
            spq_pkg::S_DSP:     n_state = spq_pkg::S_DONE;
            spq_pkg::S_RET_SCAN: begin
                if (scan_last) n_state = spq_pkg::S_DONE;
                else if (rd_data.busy) n_state = spq_pkg::S_RET_SHIFT;
            end
            spq_pkg::S_RET_SHIFT: begin
                if (shift_last) n_state = spq_pkg::S_DONE;
            end
            spq_pkg::S_DONE: begin
                if (out_free) n_state = spq_pkg::S_IDLE;
            end
            default: n_state = spq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_req       = r_req;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_status    = r_status;
        n_gtag      = r_gtag;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_wptr    = r_idx;
        ram_wdata   = new_entry;
        rd_ptr      = '0;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        case (r_state)
            spq_pkg::S_IDLE: begin
                if (in_acc) n_req = i_in_word;
            end
            spq_pkg::S_DECODE: begin
                n_status = spq_pkg::ST_OK;
                n_gtag   = '0;
                n_idx    = '0;
                case (r_req.req_type)
                    spq_pkg::REQ_INSERT: begin
                        n_idx  = r_cnt;
                        rd_ptr = r_cnt - CW'(1);
                        if (r_cnt == CW'(QUEUE_DEPTH)) n_status = spq_pkg::ST_FULL;
                    end
                    spq_pkg::REQ_DISPATCH: begin
                        if (r_cnt == '0) n_status = spq_pkg::ST_NO_DISPATCH;
                    end
                    spq_pkg::REQ_RETIRE: begin
                        if (r_cnt == '0) n_status = spq_pkg::ST_NO_RETIRE;
                    end
                    default: n_status = spq_pkg::ST_OK;
                endcase
            end
            spq_pkg::S_INS_WALK: begin
                ram_we = 1'b1;
                if (ins_here) begin
                    n_cnt = r_cnt + CW'(1);
                end else begin
                    ram_wdata = rd_data;
                    n_idx     = r_idx - CW'(1);
                    rd_ptr    = r_idx - CW'(2);
                end
            end
            spq_pkg::S_INS_PUT: begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + CW'(1);
            end
            spq_pkg::S_DSP: begin
                if (rd_data.busy) begin
                    n_status = spq_pkg::ST_NO_DISPATCH;
                end else begin
                    ram_we    = 1'b1;
                    ram_wptr  = '0;
                    ram_wdata = '{order: rd_data.order, tag: rd_data.tag, busy: 1'b1};
                    n_gtag    = rd_data.tag;
                end
            end
            spq_pkg::S_RET_SCAN: begin
                rd_ptr = r_idx + CW'(1);
                if (rd_data.busy) begin
                    n_gtag = rd_data.tag;
                    if (scan_last) n_cnt = r_cnt - CW'(1);
                end else if (scan_last) begin
                    n_status = spq_pkg::ST_NO_RETIRE;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            spq_pkg::S_RET_SHIFT: begin
                ram_we    = 1'b1;
                ram_wdata = rd_data;
                if (shift_last) begin
                    n_cnt = r_cnt - CW'(1);
                end else begin
                    rd_ptr = r_idx + CW'(2);
                    n_idx  = r_idx + CW'(1);
                end
            end
            spq_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = r_status;
                    n_out.granted_tag  = r_gtag;
                    n_out.queued_count = cnt_ext[4:0];
                end
            end
            default: n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_gtag   <= n_gtag;
        r_out    <= n_out;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != $past(r_cnt)) |->
            ((r_cnt == $past(r_cnt) + CW'(1)) || (r_cnt + CW'(1) == $past(r_cnt))))
        else $error("entry count moved by more than one");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == spq_pkg::S_IDLE) || (r_state == spq_pkg::S_DONE)) |-> !ram_we)
        else $error("ram written outside a request");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_wptr <= r_cnt) && (ram_wptr < CW'(QUEUE_DEPTH)))
        else $error("ram write beyond the held entries");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == spq_pkg::S_DONE) && out_free) |=>
            (o_out_valid && (r_state == spq_pkg::S_IDLE)))
        else $error("result not loaded on completion");
`endif

endmodule

// File: test/stable_priority_task_queue_checker.sv
// checker for the stable priority task queue: predicts each result word and compares
`timescale 1ns / 1ps

module stable_priority_task_queue_checker
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    t_entry    held_tasks [QUEUE_DEPTH];
    int        held_count;
    t_out_word awaited_replies [$];
    t_out_word oldest_reply;
    int        mismatches = 0;

    function automatic t_out_word serve_request(t_in_word req);
        t_out_word reply;
        int        pos;
        int        i;
        reply = '0;
        reply.status = ST_OK;
        case (req.req_type)
            REQ_INSERT: begin
                if (held_count >= QUEUE_DEPTH) begin
                    reply.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < held_count && held_tasks[pos].order <= req.task_order)
                        pos++;
                    for (i = held_count; i > pos; i--)
                        held_tasks[i] = held_tasks[i - 1];
                    held_tasks[pos].order = req.task_order;
                    held_tasks[pos].tag   = req.task_tag;
                    held_tasks[pos].busy  = 1'b0;
                    held_count++;
                end
            end
            REQ_DISPATCH: begin
                if (held_count == 0 || held_tasks[0].busy) begin
                    reply.status = ST_NO_DISPATCH;
                end else begin
                    held_tasks[0].busy = 1'b1;
                    reply.granted_tag = held_tasks[0].tag;
                end
            end
            REQ_RETIRE: begin
                pos = 0;
                while (pos < held_count && !held_tasks[pos].busy)
                    pos++;
                if (pos >= held_count) begin
                    reply.status = ST_NO_RETIRE;
                end else begin
                    reply.granted_tag = held_tasks[pos].tag;
                    for (i = pos; i + 1 < held_count; i++)
                        held_tasks[i] = held_tasks[i + 1];
                    held_count--;
                    held_tasks[held_count].busy = 1'b0;
                end
            end
            default: begin
            end
        endcase
        reply.queued_count = 5'(held_count);
        return reply;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            for (int i = 0; i < QUEUE_DEPTH; i++)
                held_tasks[i].busy = 1'b0;
            awaited_replies.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                awaited_replies.push_back(serve_request(i_in_word));
            if (i_out_valid && !i_out_stall) begin
                if (awaited_replies.size() == 0) begin
                    $error("result word with no request waiting: %p", i_out_word);
                    mismatches++;
                end else begin
                    oldest_reply = awaited_replies.pop_front();
                    if (i_out_word.status !== oldest_reply.status) begin
                        $error("status: expected %0d, actual %0d",
                               oldest_reply.status, i_out_word.status);
                        mismatches++;
                    end
                    if (i_out_word.granted_tag !== oldest_reply.granted_tag) begin
                        $error("granted_tag: expected %0d, actual %0d",
                               oldest_reply.granted_tag, i_out_word.granted_tag);
                        mismatches++;
                    end
                    if (i_out_word.queued_count !== oldest_reply.queued_count) begin
                        $error("queued_count: expected %0d, actual %0d",
                               oldest_reply.queued_count, i_out_word.queued_count);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= awaited_replies.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: test/stable_priority_task_queue_tb.sv
// testbench top for the stable priority task queue: stimulus, idling and verdict
`timescale 1ns / 1ps

module stable_priority_task_queue_tb;
    import spq_pkg::*;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1250;
    localparam int         IDLE_LIMIT   = 4000;
    localparam int         DRAIN_CYCLES = QUEUE_DEPTH_DEF + 16;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;
    logic      steady      = 1'b0;
    int        fail_count;
    int        pending;
    int        idle_cycles = 0;

    stable_priority_task_queue dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    stable_priority_task_queue_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_word  (o_out_word),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(0, 99) < 21);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [7:0] ord,
                                input logic [7:0] tag);
        while (!steady && $urandom_range(0, 99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= '{req_type: kind, task_order: ord, task_tag: tag};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    function automatic logic [7:0] pick_order();
        if ($urandom_range(0, 99) < 70)
            return 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int         sent;
        int         burst;
        int         roll;
        bit         filling;
        logic [1:0] kind;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue corner cases
        send_request(REQ_RETIRE,   8'h00, 8'h00);
        send_request(REQ_DISPATCH, 8'hFF, 8'hFF);
        send_request(REQ_UNUSED,   8'hA5, 8'h5A);
        // ordering with ties and extremes
        send_request(REQ_INSERT,   8'h80, 8'h55);
        send_request(REQ_INSERT,   8'h00, 8'hFF);
        send_request(REQ_INSERT,   8'h00, 8'hAA);
        send_request(REQ_INSERT,   8'hFF, 8'h00);
        send_request(REQ_DISPATCH, 8'h00, 8'h00);
        send_request(REQ_DISPATCH, 8'h00, 8'h00);
        send_request(REQ_RETIRE,   8'h00, 8'h00);
        // fill up, then overflow
        for (int k = 0; k < 13; k++)
            send_request(REQ_INSERT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_request(REQ_INSERT,   8'h40, 8'h77);
        send_request(REQ_UNUSED,   8'hFF, 8'hFF);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst   = $urandom_range(20, 60);
            filling = $urandom_range(0, 1);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                steady <= (sent >= 500 && sent < 700);
                roll = $urandom_range(0, 99);
                if (roll >= 95)
                    kind = REQ_UNUSED;
                else if (filling)
                    kind = (roll < 55) ? REQ_INSERT : (roll < 80) ? REQ_DISPATCH : REQ_RETIRE;
                else
                    kind = (roll < 15) ? REQ_INSERT : (roll < 50) ? REQ_DISPATCH : REQ_RETIRE;
                send_request(kind, pick_order(), 8'($urandom_range(0, 255)));
                if (kind != REQ_UNUSED)
                    sent++;
            end
        end

        i_in_valid <= 1'b0;
        steady     <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
